### sv/bqc_pkg.sv
package bqc_pkg;

	// filter shape
	localparam int NUM_STAGES  = 4;
	localparam int SAMPLE_BITS = 24;

	// coefficient format, signed Q2.19
	localparam int COEF_BITS = 21;
	localparam int COEF_FRAC = 19;
	localparam int NUM_TAPS  = 5;
	localparam int NUM_COEFS = NUM_STAGES * NUM_TAPS;

	// configuration port
	localparam int NUM_PACKS  = 7;
	localparam int PACK_SLOTS = 3;
	localparam int CFG_DATA_W = PACK_SLOTS * COEF_BITS;
	localparam int CFG_IDX_W  = 4;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS    = CFG_IDX_W'(0);
	localparam int                   REG_PACK_BASE = 1;

	// internal words and accumulator
	localparam int WORD_BITS = 40;
	localparam int HALF_BITS = WORD_BITS / 2;
	localparam int ACC_BITS  = 64;
	localparam int PROD_BITS = 2 * COEF_BITS;

	localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
	localparam int COEF_IDX_W = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;

	typedef enum logic [2:0] {
		COEF_A1 = 3'd0,
		COEF_A2 = 3'd1,
		COEF_B0 = 3'd2,
		COEF_B1 = 3'd3,
		COEF_B2 = 3'd4
	} coef_sel_t;

	typedef enum logic [1:0] {
		OPND_M1 = 2'd0,
		OPND_M2 = 2'd1,
		OPND_W  = 2'd2
	} opnd_sel_t;

	typedef struct packed {
		logic               load_x;
		logic               acc_init;
		logic               acc_clr;
		logic               mul_en;
		coef_sel_t          coef_sel;
		opnd_sel_t          opnd_sel;
		logic               hi_half;
		logic               sub;
		logic               round_w;
		logic               round_y;
		logic               load_out;
		logic [STAGE_W-1:0] stage;
	} dp_cmd_t;

	// (v + half lsb) >> COEF_FRAC with floor, then clamp to a word
	function automatic logic signed [WORD_BITS-1:0] round_word(
		input logic signed [ACC_BITS-1:0] v
	);
		logic signed [ACC_BITS-1:0] t;
		logic signed [ACC_BITS-1:0] s;
		logic signed [ACC_BITS-1:0] wmax;
		logic signed [ACC_BITS-1:0] wmin;
		t    = v + (ACC_BITS'(1) <<< (COEF_FRAC - 1));
		s    = t >>> COEF_FRAC;
		wmax = (ACC_BITS'(1) <<< (WORD_BITS - 1)) - ACC_BITS'(1);
		wmin = -(ACC_BITS'(1) <<< (WORD_BITS - 1));
		if (s > wmax)
			round_word = WORD_BITS'(wmax);
		else if (s < wmin)
			round_word = WORD_BITS'(wmin);
		else
			round_word = WORD_BITS'(s);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [WORD_BITS-1:0] v
	);
		logic signed [WORD_BITS-1:0] smax;
		logic signed [WORD_BITS-1:0] smin;
		smax = (WORD_BITS'(1) <<< (SAMPLE_BITS - 1)) - WORD_BITS'(1);
		smin = -(WORD_BITS'(1) <<< (SAMPLE_BITS - 1));
		if (v > smax)
			sat_sample = SAMPLE_BITS'(smax);
		else if (v < smin)
			sat_sample = SAMPLE_BITS'(smin);
		else
			sat_sample = SAMPLE_BITS'(v);
	endfunction

endpackage

### sv/bqc_ctrl.sv
module bqc_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	output logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             cfg_we,
	input  logic [bqc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bqc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output bqc_pkg::dp_cmd_t                 cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_INIT   = 9'b000000010,
		ST_MULW   = 9'b000000100,
		ST_DRAINW = 9'b000001000,
		ST_ROUNDW = 9'b000010000,
		ST_MULY   = 9'b000100000,
		ST_DRAINY = 9'b001000000,
		ST_ROUNDY = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	localparam logic [2:0] LAST_W_STEP = 3'd3;
	localparam logic [2:0] LAST_Y_STEP = 3'd5;
	localparam logic [bqc_pkg::STAGE_W-1:0] LAST_STAGE =
		bqc_pkg::STAGE_W'(bqc_pkg::NUM_STAGES - 1);

	state_t                      state_q;
	state_t                      state_d;
	logic [2:0]                  step_q;
	logic [bqc_pkg::STAGE_W-1:0] stage_q;
	logic                        bypass_q;
	logic                        out_valid_q;
	logic                        in_take;
	logic                        out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_take) state_d = bypass_q ? ST_DONE : ST_INIT;
			ST_INIT:   state_d = ST_MULW;
			ST_MULW:   if (step_q == LAST_W_STEP) state_d = ST_DRAINW;
			ST_DRAINW: state_d = ST_ROUNDW;
			ST_ROUNDW: state_d = ST_MULY;
			ST_MULY:   if (step_q == LAST_Y_STEP) state_d = ST_DRAINY;
			ST_DRAINY: state_d = ST_ROUNDY;
			ST_ROUNDY: state_d = (stage_q == LAST_STAGE) ? ST_DONE : ST_INIT;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			stage_q     <= '0;
			bypass_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MULW || state_q == ST_MULY)
				step_q <= step_q + 3'd1;
			else
				step_q <= '0;
			if (state_q == ST_IDLE)
				stage_q <= '0;
			else if (state_q == ST_ROUNDY && stage_q != LAST_STAGE)
				stage_q <= stage_q + 1'b1;
			if (cfg_we && cfg_index == bqc_pkg::REG_BYPASS)
				bypass_q <= cfg_wdata[0];
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.coef_sel = bqc_pkg::COEF_A1;
		cmd.opnd_sel = bqc_pkg::OPND_M1;
		cmd.stage    = stage_q;
		cmd.load_x   = in_take;
		cmd.acc_init = (state_q == ST_INIT);
		cmd.acc_clr  = (state_q == ST_ROUNDW);
		cmd.round_w  = (state_q == ST_ROUNDW);
		cmd.round_y  = (state_q == ST_ROUNDY);
		cmd.load_out = (state_q == ST_DONE) && out_free;
		cmd.hi_half  = !step_q[0];
		if (state_q == ST_MULW) begin
			// feedback terms: a1*m1 then a2*m2, high half first
			cmd.mul_en   = 1'b1;
			cmd.sub      = 1'b1;
			cmd.coef_sel = step_q[1] ? bqc_pkg::COEF_A2 : bqc_pkg::COEF_A1;
			cmd.opnd_sel = step_q[1] ? bqc_pkg::OPND_M2 : bqc_pkg::OPND_M1;
		end else if (state_q == ST_MULY) begin
			cmd.mul_en = 1'b1;
			case (step_q[2:1])
				2'd0: begin
					cmd.coef_sel = bqc_pkg::COEF_B0;
					cmd.opnd_sel = bqc_pkg::OPND_W;
				end
				2'd1: begin
					cmd.coef_sel = bqc_pkg::COEF_B1;
					cmd.opnd_sel = bqc_pkg::OPND_M1;
				end
				default: begin
					cmd.coef_sel = bqc_pkg::COEF_B2;
					cmd.opnd_sel = bqc_pkg::OPND_M2;
				end
			endcase
		end
	end

endmodule

### sv/bqc_datapath.sv
module bqc_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bqc_pkg::dp_cmd_t                      cmd,
	input  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out,
	input  logic                                  cfg_we,
	input  logic [bqc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	logic signed [bqc_pkg::COEF_BITS-1:0] coef_q    [bqc_pkg::NUM_COEFS];
	logic signed [bqc_pkg::WORD_BITS-1:0] delay_one_q [bqc_pkg::NUM_STAGES];
	logic signed [bqc_pkg::WORD_BITS-1:0] delay_two_q [bqc_pkg::NUM_STAGES];

	logic signed [bqc_pkg::WORD_BITS-1:0]   x_q;
	logic signed [bqc_pkg::WORD_BITS-1:0]   w_q;
	logic signed [bqc_pkg::ACC_BITS-1:0]    acc_q;
	logic signed [bqc_pkg::SAMPLE_BITS-1:0] out_q;

	logic signed [bqc_pkg::PROD_BITS-1:0] prod_s1;
	logic                                 en_s1;
	logic                                 hi_s1;
	logic                                 sub_s1;

	logic [bqc_pkg::COEF_IDX_W-1:0]       coef_idx;
	logic signed [bqc_pkg::COEF_BITS-1:0] coef;
	logic signed [bqc_pkg::WORD_BITS-1:0] m1;
	logic signed [bqc_pkg::WORD_BITS-1:0] m2;
	logic signed [bqc_pkg::WORD_BITS-1:0] opnd;
	logic signed [bqc_pkg::COEF_BITS-1:0] half;
	logic signed [bqc_pkg::ACC_BITS-1:0]  term;
	logic signed [bqc_pkg::WORD_BITS-1:0] rnd;

	assign coef_idx = bqc_pkg::COEF_IDX_W'(cmd.stage * bqc_pkg::NUM_TAPS)
		+ bqc_pkg::COEF_IDX_W'(cmd.coef_sel);
	assign coef = coef_q[coef_idx];
	assign m1   = delay_one_q[cmd.stage];
	assign m2   = delay_two_q[cmd.stage];

	always_comb begin
		case (cmd.opnd_sel)
			bqc_pkg::OPND_M1: opnd = m1;
			bqc_pkg::OPND_M2: opnd = m2;
			bqc_pkg::OPND_W:  opnd = w_q;
			default:          opnd = m1;
		endcase
	end

	// upper half signed, lower half unsigned
	always_comb begin
		if (cmd.hi_half)
			half = bqc_pkg::COEF_BITS'($signed(opnd[bqc_pkg::WORD_BITS-1:bqc_pkg::HALF_BITS]));
		else
			half = $signed({1'b0, opnd[bqc_pkg::HALF_BITS-1:0]});
	end

	always_comb begin
		term = bqc_pkg::ACC_BITS'(prod_s1);
		if (hi_s1)
			term = term <<< bqc_pkg::HALF_BITS;
	end

	assign rnd        = bqc_pkg::round_word(acc_q);
	assign sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < bqc_pkg::NUM_COEFS; k++)
				coef_q[k] <= '0;
			for (int i = 0; i < bqc_pkg::NUM_STAGES; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
			en_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				for (int p = 0; p < bqc_pkg::NUM_PACKS; p++) begin
					for (int s = 0; s < bqc_pkg::PACK_SLOTS; s++) begin
						if ((p * bqc_pkg::PACK_SLOTS + s) < bqc_pkg::NUM_COEFS &&
							cfg_index == bqc_pkg::CFG_IDX_W'(bqc_pkg::REG_PACK_BASE + p))
							coef_q[p * bqc_pkg::PACK_SLOTS + s] <=
								cfg_wdata[s * bqc_pkg::COEF_BITS +: bqc_pkg::COEF_BITS];
					end
				end
			end
			if (cmd.round_y) begin
				delay_two_q[cmd.stage] <= m1;
				delay_one_q[cmd.stage] <= w_q;
			end
			en_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * half;
		hi_s1   <= cmd.hi_half;
		sub_s1  <= cmd.sub;
		if (cmd.load_x)
			x_q <= bqc_pkg::WORD_BITS'(sample_in);
		else if (cmd.round_y)
			x_q <= rnd;
		if (cmd.round_w)
			w_q <= rnd;
		if (cmd.acc_init)
			acc_q <= bqc_pkg::ACC_BITS'(x_q) <<< bqc_pkg::COEF_FRAC;
		else if (cmd.acc_clr)
			acc_q <= '0;
		else if (en_s1)
			acc_q <= sub_s1 ? (acc_q - term) : (acc_q + term);
		if (cmd.load_out)
			out_q <= bqc_pkg::sat_sample(x_q);
	end

endmodule

### sv/biquad_cascade_lowpass.sv
// four direct-form-II biquad sections in series on signed q1.23 samples.
// each section keeps two 40-bit delay words and computes
// w = x - a1*m1 - a2*m2 then y = b0*w + b1*m1 + b2*m2, each sum rounded
// half up to the sample lsb and clamped to 40 bits; the last section's
// output is clamped to 24 bits. coefficients are signed q2.19, packed three
// to a configuration register, low field first (a1, a2, b0, b1, b2 per
// section). register 0 is bypass (reset 1): a bypassed word comes back
// unchanged and the delay words are left alone. all products go through
// one shared 21x21 multiplier, each 40-bit word split in two halves, so
// a section runs setup, the feedback half-products, a drain and a
// rounding, then the feed-forward half-products, a drain and a rounding.
// a bypassed word skips the sections. no new word is taken while one is in
// flight; the next word is taken while a result still waits at the output.
// write configuration only while the block is idle.
module biquad_cascade_lowpass (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_in,
	// sample output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [bqc_pkg::SAMPLE_BITS-1:0] sample_out,
	// configuration writes
	input  logic                                  cfg_we,
	input  logic [bqc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

	// command word from sequencer to datapath, one micro-op per cycle
	bqc_pkg::dp_cmd_t cmd;

	// sequencer: handshakes, bypass register, section and product counters
	bqc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd)
	);

	// datapath: coefficient bank, delay words, multiplier, accumulator,
	// rounding and the output word register
	bqc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

endmodule

### sim/biquad_cascade_lowpass_tb.sv
`timescale 1ns / 1ps

module biquad_cascade_lowpass_tb;

	// block dimensions
	localparam int SAMPLE_BITS   = bqc_pkg::SAMPLE_BITS;
	localparam int WORD_BITS     = bqc_pkg::WORD_BITS;
	localparam int COEF_BITS     = bqc_pkg::COEF_BITS;
	localparam int COEF_FRAC     = bqc_pkg::COEF_FRAC;
	localparam int NUM_STAGES    = bqc_pkg::NUM_STAGES;
	localparam int NUM_TAPS      = bqc_pkg::NUM_TAPS;
	localparam int NUM_COEFS     = bqc_pkg::NUM_COEFS;
	localparam int NUM_PACKS     = bqc_pkg::NUM_PACKS;
	localparam int PACK_SLOTS    = bqc_pkg::PACK_SLOTS;
	localparam int CFG_IDX_W     = bqc_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W    = bqc_pkg::CFG_DATA_W;
	localparam int REG_PACK_BASE = bqc_pkg::REG_PACK_BASE;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS = bqc_pkg::REG_BYPASS;

	// sample rails
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));
	// internal 40-bit word rails
	localparam longint WORD_HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
	localparam longint WORD_LO = -(longint'(1) <<< (WORD_BITS - 1));
	// settle time before a register write and at the end
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 100;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 160;

	// what the driver does next: offer a word, write a register, or wait for the output
	typedef enum logic [1:0] {
		OP_WORD  = 2'd0,
		OP_WRITE = 2'd1,
		OP_DRAIN = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [SAMPLE_BITS-1:0] sample;
		logic [CFG_IDX_W-1:0]   index;
		logic [CFG_DATA_W-1:0]  wdata;
		logic [15:0]            hold;
	} pending_op_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample_in  = '0;
	logic                          out_valid;
	logic                          out_stall  = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index  = '0;
	logic [CFG_DATA_W-1:0]         cfg_wdata  = '0;

	pending_op_t                   pending_ops[$];
	logic signed [SAMPLE_BITS-1:0] expected_samples[$];
	int                            taken_cnt   = 0;  // words accepted by the block
	int                            offered_cnt = 0;  // words put on the input
	int                            hold_cnt    = 0;
	int                            mismatches  = 0;

	// coefficient plan for the next programming pass
	logic signed [COEF_BITS-1:0]   plan_coef[NUM_COEFS];

	// filter state as the block should hold it
	logic                          model_bypass;
	logic signed [COEF_BITS-1:0]   model_coef[NUM_COEFS];
	logic signed [WORD_BITS-1:0]   model_m1[NUM_STAGES];
	logic signed [WORD_BITS-1:0]   model_m2[NUM_STAGES];

	biquad_cascade_lowpass i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// hard stop if the block hangs
	initial begin
		#(40_000_000);
		$display("biquad_cascade_lowpass_tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// stretch of the run where neither side idles
	function automatic bit calm_window();
		return taken_cnt >= 900 && taken_cnt < 1150;
	endfunction

	// product sum back to the sample lsb, halves up, clamped to a word
	function automatic logic signed [WORD_BITS-1:0] round_to_word(input longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (q > WORD_HI)
			q = WORD_HI;
		else if (q < WORD_LO)
			q = WORD_LO;
		return WORD_BITS'(q);
	endfunction

	// one sample through the four sections, delay words updated; bypass returns it as is
	function automatic logic signed [SAMPLE_BITS-1:0] filter_step(
		input logic signed [SAMPLE_BITS-1:0] s
	);
		longint x;
		longint m1;
		longint m2;
		longint w;
		longint y;
		int     base;
		int     st;
		if (model_bypass)
			return s;
		x = s;
		for (st = 0; st < NUM_STAGES; st++) begin
			base = st * NUM_TAPS;
			m1   = model_m1[st];
			m2   = model_m2[st];
			// feedback half: w = x - a1*m1 - a2*m2, x brought up to q.19 scale
			w = round_to_word((x <<< COEF_FRAC)
				- longint'(model_coef[base + int'(bqc_pkg::COEF_A1)]) * m1
				- longint'(model_coef[base + int'(bqc_pkg::COEF_A2)]) * m2);
			// feed-forward half
			y = round_to_word(longint'(model_coef[base + int'(bqc_pkg::COEF_B0)]) * w
				+ longint'(model_coef[base + int'(bqc_pkg::COEF_B1)]) * m1
				+ longint'(model_coef[base + int'(bqc_pkg::COEF_B2)]) * m2);
			model_m2[st] = model_m1[st];
			model_m1[st] = WORD_BITS'(w);
			x = y;
		end
		if (x > SAMPLE_HI)
			x = SAMPLE_HI;
		else if (x < SAMPLE_LO)
			x = SAMPLE_LO;
		return SAMPLE_BITS'(x);
	endfunction

	task automatic push_word(input logic [SAMPLE_BITS-1:0] s);
		pending_op_t op;
		op        = '0;
		op.kind   = OP_WORD;
		op.sample = s;
		pending_ops = {pending_ops, op};
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		pending_op_t op;
		op       = '0;
		op.kind  = OP_WRITE;
		op.index = idx;
		op.wdata = data;
		pending_ops = {pending_ops, op};
	endtask

	task automatic push_drain(input int cycles);
		pending_op_t op;
		op      = '0;
		op.kind = OP_DRAIN;
		op.hold = 16'(cycles);
		pending_ops = {pending_ops, op};
	endtask

	// wait for idle, then load every pack from the plan and set bypass
	task automatic program_filter(input bit bypass);
		logic [CFG_DATA_W-1:0] data;
		int                    r;
		int                    slot;
		int                    k;
		push_drain(SETTLE_CYCLES);
		// a stray write past the register list now and then
		if ($urandom_range(1, 0))
			push_write(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_PACK_BASE + NUM_PACKS)),
				CFG_DATA_W'({$urandom, $urandom}));
		for (r = 0; r < NUM_PACKS; r++) begin
			data = '0;
			for (slot = 0; slot < PACK_SLOTS; slot++) begin
				k = r * PACK_SLOTS + slot;
				// the top field of the last pack is unused, fill it with junk
				if (k < NUM_COEFS)
					data[slot*COEF_BITS +: COEF_BITS] = plan_coef[k];
				else
					data[slot*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
			end
			push_write(CFG_IDX_W'(REG_PACK_BASE + r), data);
		end
		// only bit 0 matters, the rest is noise
		data    = CFG_DATA_W'({$urandom, $urandom});
		data[0] = bypass;
		push_write(REG_BYPASS, data);
	endtask

	// stimulus plan
	initial begin
		logic [COEF_BITS-1:0]   rails[5];
		logic [SAMPLE_BITS-1:0] s;
		int                     i;
		int                     p;
		int                     n;
		int                     st;
		int                     pick;
		int                     a2;
		int                     lim;

		rails[0] = {1'b1, {(COEF_BITS-1){1'b0}}};  // -2
		rails[1] = {1'b0, {(COEF_BITS-1){1'b1}}};  // just under +2
		rails[2] = '0;
		rails[3] = COEF_BITS'(1);
		rails[4] = '1;                             // one lsb below zero

		// bypass after reset: rails and bit patterns come back unchanged
		push_word(SAMPLE_MAX);
		push_word(SAMPLE_MIN);
		push_word('0);
		push_word('1);
		push_word(SAMPLE_BITS'(1));
		push_word(24'h555555);
		push_word(24'haaaaaa);

		// writes past the register list must be ignored
		push_drain(SETTLE_CYCLES);
		for (i = REG_PACK_BASE + NUM_PACKS; i < 2**CFG_IDX_W; i++)
			push_write(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));

		// plain second-order low-pass in every section
		for (st = 0; st < NUM_STAGES; st++) begin
			plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_A1)] = -21'sd599261;
			plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_A2)] = 21'sd216426;
			plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B0)] = 21'sd35390;
			plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B1)] = 21'sd70779;
			plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B2)] = 21'sd35390;
		end
		program_filter(1'b0);
		// impulses, steps at both rails, tiny values
		push_word(SAMPLE_MAX);
		push_word('0);
		push_word('0);
		push_word('0);
		push_word(SAMPLE_MIN);
		push_word(SAMPLE_MIN);
		push_word(SAMPLE_MIN);
		push_word(SAMPLE_MAX);
		push_word('1);
		push_word(SAMPLE_BITS'(1));
		push_word(24'h400000);
		push_word('0);

		// random phases, each with its own setting
		for (p = 0; p < PHASES; p++) begin
			case (p % 6)
				3: begin
					// coefficients at the rails, drives the 40-bit clamps
					for (i = 0; i < NUM_COEFS; i++)
						plan_coef[i] = rails[$urandom_range(4, 0)];
				end
				4: begin
					// anything goes, mostly unstable
					for (i = 0; i < NUM_COEFS; i++)
						plan_coef[i] = COEF_BITS'($urandom);
				end
				default: begin
					// stable sections: |a2| < 0.95, |a1| < 0.95 * (1 + a2)
					for (st = 0; st < NUM_STAGES; st++) begin
						a2  = int'($urandom_range(996146, 0)) - 498073;
						lim = ((524288 + a2) * 95) / 100;
						plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_A2)] = COEF_BITS'(a2);
						plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_A1)] =
							COEF_BITS'(int'($urandom_range(2 * lim, 0)) - lim);
						plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B0)] =
							COEF_BITS'(int'($urandom_range(524288, 0)) - 262144);
						plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B1)] =
							COEF_BITS'(int'($urandom_range(524288, 0)) - 262144);
						plan_coef[st*NUM_TAPS + int'(bqc_pkg::COEF_B2)] =
							COEF_BITS'(int'($urandom_range(524288, 0)) - 262144);
					end
				end
			endcase
			program_filter(p % 6 == 2);
			for (n = 0; n < PHASE_WORDS; n++) begin
				// sender holds off until the output has caught up
				if (n == PHASE_WORDS / 2)
					push_drain(0);
				pick = $urandom_range(9, 0);
				if (pick < 6)
					s = SAMPLE_BITS'($urandom);
				else if (pick < 8)
					s = SAMPLE_BITS'(int'($urandom_range(8191, 0)) - 4096);
				else if (pick == 8)
					s = $urandom_range(1, 0) ? SAMPLE_MAX : SAMPLE_MIN;
				else
					s = '0;
				push_word(s);
			end
		end

		// all words in, all results out, then a quiet tail
		while (pending_ops.size() != 0 || taken_cnt != offered_cnt || expected_samples.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0)
			report_mismatch("results still missing at the end");
		if (mismatches == 0) begin
			$display("biquad_cascade_lowpass_tb: PASS");
		end else begin
			$display("biquad_cascade_lowpass_tb: FAIL");
		end
		$finish;
	end

	// driver: one nonblocking update per signal per falling edge
	always @(negedge clk) begin
		pending_op_t            op;
		logic                   nv;
		logic [SAMPLE_BITS-1:0] ns;
		logic                   nwe;
		logic [CFG_IDX_W-1:0]   ni;
		logic [CFG_DATA_W-1:0]  nd;
		logic                   busy;
		// a word still waiting for the block to take it
		busy = in_valid && (taken_cnt != offered_cnt);
		nv   = busy;
		ns   = sample_in;
		nwe  = 1'b0;
		ni   = cfg_index;
		nd   = cfg_wdata;
		if (arst_n && !busy) begin
			if (hold_cnt > 0) begin
				hold_cnt = hold_cnt - 1;
			end else if (pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_WORD: begin
						// random gap before the next word
						if (calm_window() || $urandom_range(99, 0) >= 28) begin
							void'(pending_ops.pop_front());
							nv          = 1'b1;
							ns          = op.sample;
							offered_cnt = offered_cnt + 1;
						end
					end
					OP_WRITE: begin
						void'(pending_ops.pop_front());
						nwe = 1'b1;
						ni  = op.index;
						nd  = op.wdata;
					end
					default: begin
						// wait until every expected result is out
						if (expected_samples.size() == 0) begin
							void'(pending_ops.pop_front());
							hold_cnt = op.hold;
						end
					end
				endcase
			end
		end
		in_valid  <= nv;
		sample_in <= ns;
		cfg_we    <= nwe;
		cfg_index <= ni;
		cfg_wdata <= nd;
	end

	// receiver backpressure
	always @(negedge clk)
		out_stall <= !calm_window() && ($urandom_range(99, 0) < 28);

	// monitor: register writes, accepted words and results at the rising edge
	always @(posedge clk) begin
		logic signed [SAMPLE_BITS-1:0] want;
		int                            k;
		int                            slot;
		int                            st;
		if (!arst_n) begin
			model_bypass = 1'b1;
			for (k = 0; k < NUM_COEFS; k++)
				model_coef[k] = '0;
			for (st = 0; st < NUM_STAGES; st++) begin
				model_m1[st] = '0;
				model_m2[st] = '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BYPASS) begin
					model_bypass = cfg_wdata[0];
				end else if (cfg_index >= REG_PACK_BASE && cfg_index < REG_PACK_BASE + NUM_PACKS) begin
					for (slot = 0; slot < PACK_SLOTS; slot++) begin
						k = (int'(cfg_index) - REG_PACK_BASE) * PACK_SLOTS + slot;
						if (k < NUM_COEFS)
							model_coef[k] = cfg_wdata[slot*COEF_BITS +: COEF_BITS];
					end
				end
				// indexes past the list change nothing
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected", sample_out));
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want)
						report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want));
				end
			end
			if (in_valid && !in_stall) begin
				expected_samples = {expected_samples, filter_step(sample_in)};
				taken_cnt <= taken_cnt + 1;
			end
		end
	end

endmodule
